// ===== design/pcds_pkg.sv =====
// Shared constants and types for the pixel clock divider search.
`timescale 1ns / 1ps
`default_nettype none

package pcds_pkg;

  // Field widths
  localparam int unsigned TgtW  = 20;  // requested clock, base clock, error
  localparam int unsigned FracW = 6;   // fractional setting
  localparam int unsigned DselW = 8;   // integer divider
  localparam int unsigned ClkW  = 25;  // base * 18 / frac
  localparam int unsigned DvdW  = 26;  // divider dividend (clk + tgt - 1)

  // Search range and limits
  localparam logic [FracW-1:0] FracMin   = 6'd18;
  localparam logic [FracW-1:0] FracEnd   = 6'd36;
  localparam logic [DvdW-1:0]  DivMax    = 26'd255;
  localparam logic [TgtW-1:0]  BaseReset = 20'd480000;

  // Result status codes
  localparam logic StatOk    = 1'b0;
  localparam logic StatRange = 1'b1;

  // Request to the shared divider
  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [TgtW-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider
  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/pcds_if.sv =====
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface pcds_req_if;
  import pcds_pkg::*;

  logic            valid;
  logic            ready;
  logic [TgtW-1:0] pixel_clock_khz;

  modport source (output valid, output pixel_clock_khz, input ready);
  modport sink   (input valid, input pixel_clock_khz, output ready);
endinterface

interface pcds_rsp_if;
  import pcds_pkg::*;

  logic             valid;
  logic             ready;
  logic [FracW-1:0] best_fraction;
  logic [DselW-1:0] divider;
  logic [TgtW-1:0]  error_khz;
  logic             status;

  modport source (output valid, output best_fraction, output divider,
                  output error_khz, output status, input ready);
  modport sink   (input valid, input best_fraction, input divider,
                  input error_khz, input status, output ready);
endinterface

`default_nettype wire

// ===== design/pcds_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pcds_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire pcds_pkg::div_req_t req_i,
  output pcds_pkg::div_rsp_t  rsp_o
);
  import pcds_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW);
  localparam logic [CntW-1:0] CntLast = CntW'(DvdW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [TgtW-1:0] rem_q, rem_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [TgtW-1:0] dsr_q, dsr_d;

  logic [TgtW:0]   trial;
  logic [TgtW:0]   diff;
  logic            fits;

  assign trial = {rem_q, quo_q[DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[TgtW-1:0] : trial[TgtW-1:0];
      quo_d = {quo_q[DvdW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  // A new division is only launched on an idle unit.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // The last step is followed by a done pulse.
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == CntLast) |=> done_q)
    else $error("divider missed its done pulse");

  // Done is only raised once the unit has stopped.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

`default_nettype wire

// ===== design/pixel_clock_divider_search.sv =====
// Top level: pixel clock divider search sequencer around a shared divider.
`timescale 1ns / 1ps
`default_nettype none

// Pixel clock divider search. A request beat carries the wanted pixel clock
// in kHz; the block walks fractional settings 18..35, for each one forming
// the source clock base*18/frac, the rounded-up integer divider and the
// error of the clock it yields, and returns one result beat with the first
// setting of least error (status 1 and zero fields when nothing usable is
// found or the request is zero). The search ends early when the source clock
// drops below the request or an exact match turns up; dividers over 255 are
// skipped. All three divisions of a setting run through one shared restoring
// divider that retires one quotient bit a cycle; a zero request skips the
// search and goes straight to the result. Requests are taken only while the
// sequencer is idle; a finished result sits in an output register, so a new
// request can start while the previous result waits. The base clock register
// (reset 480000 kHz) is written through cfg_we_i/cfg_data_i and must only
// change while no request is in flight.
module pixel_clock_divider_search (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [pcds_pkg::TgtW-1:0]       cfg_data_i,
  pcds_req_if.sink                       req_i,
  pcds_rsp_if.source                     rsp_o
);
  import pcds_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,  // launch base*18/frac or finish the sweep
    S_CLK   = 6'b000100,  // waiting for the source clock
    S_CEIL  = 6'b001000,  // waiting for the rounded-up divider
    S_GOT   = 6'b010000,  // waiting for the achieved clock
    S_DONE  = 6'b100000   // hand the result to the output register
  } state_e;

  state_e           state_q, state_d;
  logic [TgtW-1:0]  base_q;
  logic [TgtW-1:0]  tgt_q, tgt_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [ClkW-1:0]  clk_q, clk_d;
  logic             found_q, found_d;
  logic [FracW-1:0] bfrac_q, bfrac_d;
  logic [DselW-1:0] bdiv_q, bdiv_d;
  logic [TgtW-1:0]  berr_q, berr_d;

  logic             ovld_q, ovld_d;
  logic [FracW-1:0] ofrac_q, ofrac_d;
  logic [DselW-1:0] odiv_q, odiv_d;
  logic [TgtW-1:0]  oerr_q, oerr_d;
  logic             ostat_q, ostat_d;

  // Divider chosen in S_CEIL, held for the achieved-clock division.
  logic [DselW-1:0] dreq_div_q;

  div_req_t         dreq;
  div_rsp_t         drsp;

  logic [ClkW-1:0]  base18;
  logic [ClkW-1:0]  quo_clk;
  logic [ClkW-1:0]  tgt_ext;
  logic [ClkW-1:0]  err_ext;
  logic [TgtW-1:0]  err;
  logic             better;
  logic             req_fire;

  pcds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // base * 18 as a shift-add
  assign base18  = (ClkW'(base_q) << 4) + (ClkW'(base_q) << 1);
  assign quo_clk = drsp.quot[ClkW-1:0];
  assign tgt_ext = ClkW'(tgt_q);
  assign err_ext = (quo_clk > tgt_ext) ? (quo_clk - tgt_ext) : (tgt_ext - quo_clk);
  assign err     = err_ext[TgtW-1:0];
  assign better  = !found_q || (err < berr_q);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    state_d = state_q;
    tgt_d   = tgt_q;
    frac_d  = frac_q;
    clk_d   = clk_q;
    found_d = found_q;
    bfrac_d = bfrac_q;
    bdiv_d  = bdiv_q;
    berr_d  = berr_q;
    ovld_d  = ovld_q && !rsp_o.ready;
    ofrac_d = ofrac_q;
    odiv_d  = odiv_q;
    oerr_d  = oerr_q;
    ostat_d = ostat_q;
    dreq    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          tgt_d   = req_i.pixel_clock_khz;
          frac_d  = FracMin;
          found_d = 1'b0;
          bfrac_d = '0;
          bdiv_d  = '0;
          berr_d  = '0;
          state_d = (req_i.pixel_clock_khz == '0) ? S_DONE : S_START;
        end
      end
      S_START: begin
        if (frac_q == FracEnd) begin
          state_d = S_DONE;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = DvdW'(base18);
          dreq.divisor  = TgtW'(frac_q);
          state_d       = S_CLK;
        end
      end
      S_CLK: begin
        if (drsp.done) begin
          clk_d = quo_clk;
          if (quo_clk < tgt_ext) begin
            state_d = S_DONE;
          end else begin
            // ceil(clk / tgt) as (clk + tgt - 1) / tgt
            dreq.start    = 1'b1;
            dreq.dividend = DvdW'(quo_clk) + DvdW'(tgt_q) - DvdW'(1);
            dreq.divisor  = tgt_q;
            state_d       = S_CEIL;
          end
        end
      end
      S_CEIL: begin
        if (drsp.done) begin
          if (drsp.quot > DivMax) begin
            frac_d  = frac_q + 1'b1;
            state_d = S_START;
          end else begin
            dreq.start    = 1'b1;
            dreq.dividend = DvdW'(clk_q);
            dreq.divisor  = TgtW'(drsp.quot[DselW-1:0]);
            state_d       = S_GOT;
          end
        end
      end
      S_GOT: begin
        if (drsp.done) begin
          frac_d  = frac_q + 1'b1;
          state_d = S_START;
          if (better) begin
            found_d = 1'b1;
            bfrac_d = frac_q;
            bdiv_d  = dreq_div_q;
            berr_d  = err;
            if (err == '0) begin
              frac_d  = frac_q;
              state_d = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (!ovld_q || rsp_o.ready) begin
          ovld_d  = 1'b1;
          ofrac_d = found_q ? bfrac_q : '0;
          odiv_d  = found_q ? bdiv_q : '0;
          oerr_d  = found_q ? berr_q : '0;
          ostat_d = found_q ? StatOk : StatRange;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CEIL && drsp.done) begin
      dreq_div_q <= drsp.quot[DselW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q  <= BaseReset;
      ovld_q  <= 1'b0;
      found_q <= 1'b0;
      frac_q  <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      found_q <= found_d;
      frac_q  <= frac_d;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q   <= tgt_d;
    clk_q   <= clk_d;
    bfrac_q <= bfrac_d;
    bdiv_q  <= bdiv_d;
    berr_q  <= berr_d;
    ofrac_q <= ofrac_d;
    odiv_q  <= odiv_d;
    oerr_q  <= oerr_d;
    ostat_q <= ostat_d;
  end

  assign rsp_o.valid         = ovld_q;
  assign rsp_o.best_fraction = ofrac_q;
  assign rsp_o.divider       = odiv_q;
  assign rsp_o.error_khz     = oerr_q;
  assign rsp_o.status        = ostat_q;

  // The rounded-up divider is never zero once the clock covers the request.
  a_ceil_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CEIL && drsp.done) |-> (drsp.quot != '0))
    else $error("rounded-up divider is zero");

  // Divider answers only arrive while the sequencer waits for one.
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == S_CLK || state_q == S_CEIL || state_q == S_GOT))
    else $error("divider answer outside a wait state");

  // An accepted request always starts the search or goes straight to done.
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_START || state_q == S_DONE))
    else $error("request accepted but search not started");

  // A reported setting stays inside the swept range.
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == StatOk) |->
      (rsp_o.best_fraction >= FracMin && rsp_o.best_fraction < FracEnd))
    else $error("reported fraction out of range");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for the pixel clock divider search: random and directed requests.
`timescale 1ns / 1ps

// Bench structure
//   - An initial block runs the phases. Each phase may rewrite the base clock
//     register, then queues request beats into req_pending_q and waits until
//     every predicted setting has come back. Base clock writes happen only
//     while the block is idle.
//   - The request driver offers queued beats on req_if. On each accepted beat
//     it runs search_divider() against the bench copy of the base clock, and
//     pushes the predicted setting onto divider_pick_q.
//   - The result monitor drives rsp_if.ready. It checks every accepted result
//     beat, field by field, against the oldest entry of divider_pick_q.
//   - A watchdog ends the run if no beat moves on either side before its
//     quiet counter reaches QuietLimit.
// Both sides idle in random bursts. The last phase runs with no idling. In
// one phase the monitor holds ready low through its long hold (LongHold)
// while the driver keeps offering, so the result register fills and the
// request side stalls. The phase boundaries are points where the sender
// pauses until every result has come back.
module tb_top;
  import pcds_pkg::*;

  localparam int unsigned UnityFrac  = 18;     // base * 18 / frac
  localparam int unsigned LongHold   = 4000;   // covers two full searches
  localparam int unsigned QuietLimit = 16000;  // long hold + a full search, with margin
  localparam int unsigned TailCycles = 2000;   // covers a full search, with margin

  // One result beat, as predicted
  typedef struct packed {
    logic [FracW-1:0] best_fraction;
    logic [DselW-1:0] divider;
    logic [TgtW-1:0]  error_khz;
    logic             status;
  } div_pick_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [TgtW-1:0] cfg_data;

  pcds_req_if req_if ();
  pcds_rsp_if rsp_if ();

  pixel_clock_divider_search dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  // Bench state
  logic [TgtW-1:0] base_khz;              // bench copy of the base clock register
  logic [TgtW-1:0] req_pending_q[$];      // request beats not yet offered
  div_pick_t       divider_pick_q[$];     // predicted settings, oldest first
  bit              idle_on;
  int unsigned     n_sent;
  int unsigned     n_results;
  int unsigned     n_errors;
  int unsigned     long_hold_ask;
  int unsigned     long_hold_seen;
  int unsigned     src_gap;
  int unsigned     sink_hold;
  int unsigned     quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Walk fractions 18..35. Stop when the source clock drops below the
  // request, or on an exact hit. Skip dividers over the limit. The first
  // setting with the least error wins.
  function automatic div_pick_t search_divider(input logic [TgtW-1:0] base,
                                               input logic [TgtW-1:0] target);
    div_pick_t         pick;
    longint unsigned   tgt, src_clk, dv, got, diff, best_err;
    int unsigned       fr;
    bit                found, stop;
    pick     = '0;
    tgt      = target;
    best_err = 0;
    found    = 1'b0;
    stop     = 1'b0;
    if (tgt != 0) begin
      for (fr = FracMin; fr < FracEnd && !stop; fr++) begin
        src_clk = (longint'(base) * UnityFrac) / fr;
        if (src_clk < tgt) begin
          stop = 1'b1;
        end else begin
          dv = (src_clk + tgt - 1) / tgt;  // rounded up, at least 1
          if (dv <= DivMax) begin
            got  = src_clk / dv;
            diff = (got > tgt) ? got - tgt : tgt - got;
            if (!found || diff < best_err) begin
              found              = 1'b1;
              pick.best_fraction = fr[FracW-1:0];
              pick.divider       = dv[DselW-1:0];
              best_err           = diff;
              if (diff == 0) stop = 1'b1;
            end
          end
        end
      end
    end
    if (found) begin
      pick.error_khz = best_err[TgtW-1:0];
      pick.status    = StatOk;
    end else begin
      pick        = '0;
      pick.status = StatRange;
    end
    return pick;
  endfunction

  // Random request. Most land close to clk/d for a reachable setting; the
  // rest are wide noise, tiny requests, and the odd zero.
  function automatic logic [TgtW-1:0] pick_target(input logic [TgtW-1:0] base);
    longint unsigned src_clk, t;
    int unsigned     sel;
    sel     = $urandom_range(0, 39);
    src_clk = (longint'(base) * UnityFrac) / $urandom_range(FracMin, FracEnd - 1);
    if (sel == 0) begin
      t = 0;
    end else if (sel < 5) begin
      t = $urandom & 32'h000F_FFFF;
    end else if (sel < 8) begin
      t = $urandom_range(1, 4000);
    end else begin
      t = src_clk / $urandom_range(1, (sel < 20) ? 16 : 255);
      if ($urandom_range(0, 1) == 1) t = t + $urandom_range(0, 6);
      if (t > 3) t = t - $urandom_range(0, 3);
      if (t == 0) t = 1;
      if (t > 64'h000F_FFFF) t = 64'h000F_FFFF;
    end
    return t[TgtW-1:0];
  endfunction

  task automatic queue_request(input logic [TgtW-1:0] khz);
    req_pending_q.push_back(khz);
    n_sent++;
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) queue_request(pick_target(base_khz));
  endtask

  // Sender pause: nothing more goes out until every result is back.
  task automatic wait_drained();
    while (n_results < n_sent || divider_pick_q.size() != 0) @(posedge clk_i);
  endtask

  // Base clock write, only while the block is idle
  task automatic set_base(input logic [TgtW-1:0] khz);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= khz;
    base_khz = khz;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic note_fault(input string what);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // Request driver: one beat on offer at a time. It stays up until accepted,
  // and a random gap may follow the beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid           <= 1'b0;
      req_if.pixel_clock_khz <= '0;
      src_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        divider_pick_q.push_back(search_divider(base_khz, req_if.pixel_clock_khz));
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          req_if.valid <= 1'b0;
        end else if (req_pending_q.size() > 0) begin
          req_if.valid           <= 1'b1;
          req_if.pixel_clock_khz <= req_pending_q.pop_front();
          if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 8);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat, and stalls in bursts or in the long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    div_pick_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_results++;
        if (divider_pick_q.size() == 0) begin
          note_fault($sformatf("result beat with nothing expected: frac %0d div %0d err %0d st %0d",
                               rsp_if.best_fraction, rsp_if.divider, rsp_if.error_khz,
                               rsp_if.status));
        end else begin
          want = divider_pick_q.pop_front();
          if (rsp_if.best_fraction !== want.best_fraction || rsp_if.divider !== want.divider ||
              rsp_if.error_khz !== want.error_khz || rsp_if.status !== want.status) begin
            note_fault($sformatf({"mismatch: exp frac %0d div %0d err %0d st %0d, ",
                                  "got frac %0d div %0d err %0d st %0d"},
                                 want.best_fraction, want.divider, want.error_khz, want.status,
                                 rsp_if.best_fraction, rsp_if.divider, rsp_if.error_khz,
                                 rsp_if.status));
          end
        end
      end
      if (long_hold_ask != long_hold_seen) begin
        long_hold_seen = long_hold_ask;
        sink_hold      = LongHold;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(0, 7);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a beat must move on one side or the other now and then.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("pixel_clock_divider_search regression: fail");
        $finish;
      end
    end
  end

  // Phases
  initial begin
    logic [TgtW-1:0] corner_khz[20];
    corner_khz = '{
      20'd0,       20'd1,       20'hFFFFF,   20'd480000,  20'd240000,
      20'd480001,  20'd1882,    20'd1883,    20'd2,       20'd100,
      20'd27000,   20'd148500,  20'd74250,   20'd65000,   20'd25175,
      20'd524288,  20'hAAAAA,   20'h55555,   20'd246858,  20'd246857
    };
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    req_if.valid   = 1'b0;
    req_if.pixel_clock_khz = '0;
    rsp_if.ready   = 1'b0;
    base_khz       = BaseReset;
    idle_on        = 1'b1;
    n_sent         = 0;
    n_results      = 0;
    n_errors       = 0;
    long_hold_ask  = 0;
    long_hold_seen = 0;
    quiet_cycles   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset base clock. Directed corners: zero request, full scale, exact
    // hits, a request above the source clock, and a divider just past 255.
    foreach (corner_khz[i]) queue_request(corner_khz[i]);
    wait_drained();

    // Top of the base clock range. The receiver stalls long enough that the
    // output register and the search both fill up.
    set_base(20'hFFFFF);
    long_hold_ask++;
    queue_random(120);
    wait_drained();

    // Bottom of the specified base range
    set_base(20'd1000);
    queue_request(20'd1000);
    queue_request(20'd514);
    queue_request(20'd3);
    queue_random(90);
    wait_drained();

    // Tiny base clock: the source clock goes to zero past frac 18
    set_base(20'd1);
    queue_request(20'd1);
    queue_request(20'd2);
    queue_request(20'hFFFFF);
    queue_random(5);
    wait_drained();

    // Base clock of zero: nothing is usable
    set_base(20'd0);
    queue_request(20'd1);
    queue_request(20'd0);
    wait_drained();

    // Random base clock
    set_base(20'($urandom_range(1000, 1048575)));
    queue_random(200);
    wait_drained();

    // Back to the reset value, no idling on either side
    set_base(BaseReset);
    idle_on = 1'b0;
    queue_random(150);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0 && divider_pick_q.size() == 0) begin
      $display("pixel_clock_divider_search regression: pass");
    end else begin
      $display("pixel_clock_divider_search regression: fail");
    end
    $finish;
  end

endmodule
